FILE: src/emb_pkg.sv
// Shared types and constants for the mediating-block extractor.
// Holds the channel payloads, the tally control group and a bit-count helper.
// No dependencies.
package emb_pkg;

   // Input width of the bit-count helper; the channel fields bound the graph at 32 nodes.
   localparam int MAX_NODES = 64;
   localparam int POP_W     = 7;

   // Fixed field widths of the channels.
   localparam int ROW_W  = 32;
   localparam int IDX_W  = 5;
   localparam int SIZE_W = 5;
   localparam int EDGE_W = 9;
   localparam int MASK_W = 32;

   localparam logic FUNC_WRITE_ROW = 1'b0;
   localparam logic FUNC_QUERY     = 1'b1;

   typedef struct packed {
      logic             func;
      logic [IDX_W-1:0] row_index;
      logic [ROW_W-1:0] row_bits;
      logic [IDX_W-1:0] node_i;
      logic [IDX_W-1:0] node_j;
   } req_payload_type;

   typedef struct packed {
      logic              valid_res;
      logic [SIZE_W-1:0] block_size;
      logic [SIZE_W-1:0] common_count;
      logic [EDGE_W-1:0] common_edges;
      logic [EDGE_W-1:0] bridge_edges;
      logic [SIZE_W-1:0] max_bridge_degree;
      logic [EDGE_W-1:0] block_edges;
      logic [MASK_W-1:0] block_mask;
      logic [MASK_W-1:0] side_i_mask;
      logic [MASK_W-1:0] side_j_mask;
   } rsp_payload_type;

   // Control from the sequencer to the counting datapath.
   typedef struct packed {
      logic clear;     // start of a query: zero all accumulators
      logic row_en;    // a counting-sweep row is on the memory read data
      logic shift_en;  // one step of the degree scan
   } tally_ctl_type;

   // Counts set bits in groups of eight, then adds the group counts.
   function automatic logic [POP_W-1:0] popcount(input logic [MAX_NODES-1:0] vec);
      logic [3:0]       group;
      logic [POP_W-1:0] total;
      total = '0;
      for (int g = 0; g < MAX_NODES / 8; g++) begin
         group = '0;
         for (int b = 0; b < 8; b++) begin
            group = group + 4'(vec[g*8+b]);
         end
         total = total + POP_W'(group);
      end
      return total;
   endfunction

endpackage

FILE: src/emb_channels_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on emb_pkg for the payload types.
interface emb_req_if
   import emb_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface emb_rsp_if
   import emb_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/emb_row_mem.sv
// Adjacency row store: one row of NODES bits per node.
// Synchronous write, registered synchronous read. No dependencies.
module emb_row_mem #(
   parameter int NODES = 32,
   localparam int NODE_W = $clog2(NODES)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [NODE_W-1:0] wr_addr,
   input  logic [NODES-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [NODE_W-1:0] rd_addr,
   output logic [NODES-1:0]  rd_data
);

   logic [NODES-1:0] rows_mem [NODES];
   logic [NODES-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rows_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/emb_ctrl.sv
// Query sequencer: row writes, query row reads, the marking sweep that
// builds the block set, and the timing of the counting sweep and degree scan.
// Depends on emb_pkg.
module emb_ctrl
   import emb_pkg::*;
#(
   parameter int NODES = 32,
   localparam int NODE_W = $clog2(NODES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_payload_type   req_data,
   input  logic              out_free,
   output logic              idle,
   output logic              mem_wr_en,
   output logic [NODE_W-1:0] mem_wr_addr,
   output logic [NODES-1:0]  mem_wr_data,
   output logic              mem_rd_en,
   output logic [NODE_W-1:0] mem_rd_addr,
   input  logic [NODES-1:0]  mem_rd_data,
   output logic [NODES-1:0]  common_set,
   output logic [NODES-1:0]  block_set,
   output logic [NODES-1:0]  side_i_set,
   output logic [NODES-1:0]  side_j_set,
   output tally_ctl_type     tally_ctl,
   output logic [NODE_W-1:0] tally_row,
   output logic              finish
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ_I = 3'd1;
   localparam logic [2:0] ST_READ_J = 3'd2;
   localparam logic [2:0] ST_MARK   = 3'd3;
   localparam logic [2:0] ST_COUNT  = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_SCAN   = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   // What the memory read data holds in the current cycle.
   localparam logic [2:0] TAG_NONE  = 3'd0;
   localparam logic [2:0] TAG_ROW_I = 3'd1;
   localparam logic [2:0] TAG_ROW_J = 3'd2;
   localparam logic [2:0] TAG_MARK  = 3'd3;
   localparam logic [2:0] TAG_COUNT = 3'd4;

   localparam logic [NODE_W-1:0] LAST_ROW = NODE_W'(NODES - 1);

   logic [2:0]        state_ff, state_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]  node_i_ff, node_i_in;
   logic [IDX_W-1:0]  node_j_ff, node_j_in;
   logic [2:0]        tag_ff, tag_in;
   logic [NODE_W-1:0] tag_row_ff;
   logic [NODES-1:0]  row_i_ff, row_i_in;
   logic [NODES-1:0]  row_j_ff, row_j_in;
   logic [NODES-1:0]  block_ff, block_in;

   logic              in_range_i, in_range_j;
   logic [NODE_W-1:0] addr_i, addr_j;
   logic [NODES-1:0]  avail;
   logic [NODES-1:0]  only_i, only_j;
   logic [NODES-1:0]  mark_hits;

   assign in_range_i = int'(node_i_ff) < NODES;
   assign in_range_j = int'(node_j_ff) < NODES;
   assign addr_i     = NODE_W'(node_i_ff);
   assign addr_j     = NODE_W'(node_j_ff);
   assign avail      = ~((in_range_i ? (NODES'(1) << addr_i) : '0) |
                         (in_range_j ? (NODES'(1) << addr_j) : '0));

   assign common_set = row_i_ff & row_j_ff;
   assign only_i     = row_i_ff & ~row_j_ff;
   assign only_j     = row_j_ff & ~row_i_ff;
   assign block_set  = block_ff;
   assign side_i_set = only_i & block_ff;
   assign side_j_set = only_j & block_ff;

   // Writes are taken only while idle, so they never meet a query read.
   assign idle        = state_ff == ST_IDLE;
   assign mem_wr_en   = accept && (req_data.func == FUNC_WRITE_ROW) &&
                        (int'(req_data.row_index) < NODES);
   assign mem_wr_addr = NODE_W'(req_data.row_index);
   assign mem_wr_data = NODES'(req_data.row_bits);

   assign tally_row = tag_row_ff;

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      node_i_in          = node_i_ff;
      node_j_in          = node_j_ff;
      mem_rd_en          = 1'b0;
      mem_rd_addr        = cnt_ff;
      tag_in             = TAG_NONE;
      finish             = 1'b0;
      tally_ctl.clear    = 1'b0;
      tally_ctl.row_en   = tag_ff == TAG_COUNT;
      tally_ctl.shift_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.func == FUNC_QUERY)) begin
               node_i_in = req_data.node_i;
               node_j_in = req_data.node_j;
               state_in  = ST_READ_I;
            end
         end
         ST_READ_I: begin
            mem_rd_en       = 1'b1;
            mem_rd_addr     = addr_i;
            tag_in          = TAG_ROW_I;
            tally_ctl.clear = 1'b1;
            state_in        = ST_READ_J;
         end
         ST_READ_J: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = addr_j;
            tag_in      = TAG_ROW_J;
            cnt_in      = '0;
            state_in    = ST_MARK;
         end
         ST_MARK: begin
            mem_rd_en = 1'b1;
            tag_in    = TAG_MARK;
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_COUNT;
            end else begin
               cnt_in = cnt_ff + NODE_W'(1);
            end
         end
         ST_COUNT: begin
            mem_rd_en = 1'b1;
            tag_in    = TAG_COUNT;
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + NODE_W'(1);
            end
         end
         ST_DRAIN: begin
            // Lets the last counted row pass the read register and the tally registers into the degree counters.
            if (cnt_ff == NODE_W'(1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + NODE_W'(1);
            end
         end
         ST_SCAN: begin
            tally_ctl.shift_en = 1'b1;
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + NODE_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read data handling: query rows, then the marking sweep grows the block.
   assign mark_hits = mem_rd_data & only_j;

   always_comb begin
      row_i_in = row_i_ff;
      row_j_in = row_j_ff;
      block_in = block_ff;
      case (tag_ff)
         TAG_ROW_I: begin
            row_i_in = in_range_i ? (mem_rd_data & avail) : '0;
         end
         TAG_ROW_J: begin
            row_j_in = in_range_j ? (mem_rd_data & avail) : '0;
            block_in = row_i_ff & row_j_in;
         end
         TAG_MARK: begin
            if (only_i[tag_row_ff] && (|mark_hits)) begin
               block_in = block_ff | (NODES'(1) << tag_row_ff) | mark_hits;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         tag_ff   <= TAG_NONE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      node_i_ff  <= node_i_in;
      node_j_ff  <= node_j_in;
      tag_row_ff <= mem_rd_addr;
      row_i_ff   <= row_i_in;
      row_j_ff   <= row_j_in;
      block_ff   <= block_in;
   end

endmodule

FILE: src/emb_tally.sv
// Counting datapath: per-row edge counts for the common set, the block and the
// bridges, per-node bridge degree counters and the scan for the largest degree.
// Depends on emb_pkg.
module emb_tally
   import emb_pkg::*;
#(
   parameter int NODES = 32,
   localparam int NODE_W = $clog2(NODES),
   localparam int DEG_W = $clog2(NODES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  tally_ctl_type     tally_ctl,
   input  logic [NODE_W-1:0] count_row,
   input  logic [NODES-1:0]  row_data,
   input  logic [NODES-1:0]  common_set,
   input  logic [NODES-1:0]  block_set,
   input  logic [NODES-1:0]  side_i_set,
   input  logic [NODES-1:0]  side_j_set,
   output logic [EDGE_W-1:0] common_edges,
   output logic [EDGE_W-1:0] bridge_edges,
   output logic [EDGE_W-1:0] block_edges,
   output logic [SIZE_W-1:0] max_bridge_degree
);

   logic [NODES-1:0] row_onehot;
   logic [NODES-1:0] upper;
   logic [NODES-1:0] common_hits, block_hits, bridge_hits;

   logic                         row_valid_ff;
   logic [NODE_W-1:0]            row_ff;
   logic [DEG_W-1:0]             pc_common_ff, pc_block_ff, pc_bridge_ff;
   logic [NODES-1:0]             bridge_hits_ff;
   logic [EDGE_W-1:0]            common_sum_ff, block_sum_ff, bridge_sum_ff;
   logic [NODES-1:0][DEG_W-1:0]  degree_ff, degree_in;
   logic [DEG_W-1:0]             max_ff;

   // An edge between u < v lives in row u, so only bits above the row count.
   assign row_onehot = NODES'(1) << count_row;
   assign upper      = row_data & ~(row_onehot | (row_onehot - NODES'(1)));

   always_comb begin
      common_hits = common_set[count_row] ? (upper & common_set) : '0;
      block_hits  = block_set[count_row] ? (upper & block_set) : '0;
      if (side_i_set[count_row]) begin
         bridge_hits = upper & side_j_set;
      end else if (side_j_set[count_row]) begin
         bridge_hits = upper & side_i_set;
      end else begin
         bridge_hits = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= tally_ctl.row_en;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= count_row;
      pc_common_ff   <= DEG_W'(popcount(MAX_NODES'(common_hits)));
      pc_block_ff    <= DEG_W'(popcount(MAX_NODES'(block_hits)));
      pc_bridge_ff   <= DEG_W'(popcount(MAX_NODES'(bridge_hits)));
      bridge_hits_ff <= bridge_hits;
   end

   always_ff @(posedge clock) begin
      if (tally_ctl.clear) begin
         common_sum_ff <= '0;
         block_sum_ff  <= '0;
         bridge_sum_ff <= '0;
      end else if (row_valid_ff) begin
         common_sum_ff <= common_sum_ff + EDGE_W'(pc_common_ff);
         block_sum_ff  <= block_sum_ff + EDGE_W'(pc_block_ff);
         bridge_sum_ff <= bridge_sum_ff + EDGE_W'(pc_bridge_ff);
      end
   end

   // Each node's counter gets one for every bridge from a lower row and the
   // whole bridge count of its own row. The scan then shifts them out.
   always_comb begin
      degree_in = degree_ff;
      if (tally_ctl.clear) begin
         degree_in = '0;
      end else if (row_valid_ff) begin
         for (int v = 0; v < NODES; v++) begin
            degree_in[v] = degree_ff[v] + DEG_W'(bridge_hits_ff[v]) +
                           ((row_ff == NODE_W'(v)) ? pc_bridge_ff : '0);
         end
      end else if (tally_ctl.shift_en) begin
         degree_in = degree_ff >> DEG_W;
      end
   end

   always_ff @(posedge clock) begin
      degree_ff <= degree_in;
      if (tally_ctl.clear) begin
         max_ff <= '0;
      end else if (tally_ctl.shift_en && (degree_ff[0] > max_ff)) begin
         max_ff <= degree_ff[0];
      end
   end

   assign common_edges      = common_sum_ff;
   assign bridge_edges      = bridge_sum_ff;
   assign block_edges       = block_sum_ff;
   assign max_bridge_degree = SIZE_W'(max_ff);

endmodule

FILE: src/edge_mediating_block_extract.sv
// Channel | Dir | Transfer moves
// req     | in  | one row write (func 0) or one block query (func 1)
// rsp     | out | one result per query, none per row write
//
// A query occupies the block after its transfer for two row reads, a marking sweep
// and a counting sweep of NODES reads each through the single read port of the row
// memory, a drain of the tally registers, then a NODES-step scan of the per-node
// degree counters. Reset clears control state only; rows read as undefined until
// written. A result waits in the output register while new items are taken; a
// later query holds in its last step until that register frees.
// Top level of the mediating-block extractor. Depends on emb_pkg,
// emb_channels_if, emb_row_mem, emb_ctrl and emb_tally.
module edge_mediating_block_extract
   import emb_pkg::*;
#(
   parameter int NODES = 32
) (
   input  logic        clock,
   input  logic        reset,
   emb_req_if.sink     req_port,
   emb_rsp_if.source   rsp_port
);

   localparam int NODE_W = $clog2(NODES);

   logic              ctrl_idle;
   logic              req_accept;
   logic              out_free;
   logic              finish;
   logic              mem_wr_en, mem_rd_en;
   logic [NODE_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [NODES-1:0]  mem_wr_data, mem_rd_data;
   logic [NODES-1:0]  common_set, block_set, side_i_set, side_j_set;
   tally_ctl_type     tally_ctl;
   logic [NODE_W-1:0] tally_row;
   logic [EDGE_W-1:0] common_edges, bridge_edges, block_edges;
   logic [SIZE_W-1:0] max_bridge_degree;

   logic              result_ok;
   rsp_payload_type   result;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff;

   assign req_port.ready = ctrl_idle && !reset;
   assign req_accept     = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   emb_row_mem #(.NODES(NODES)) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   emb_ctrl #(.NODES(NODES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_data    (req_port.payload),
      .out_free    (out_free),
      .idle        (ctrl_idle),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .common_set  (common_set),
      .block_set   (block_set),
      .side_i_set  (side_i_set),
      .side_j_set  (side_j_set),
      .tally_ctl   (tally_ctl),
      .tally_row   (tally_row),
      .finish      (finish)
   );

   emb_tally #(.NODES(NODES)) u_tally (
      .clock             (clock),
      .reset             (reset),
      .tally_ctl         (tally_ctl),
      .count_row         (tally_row),
      .row_data          (mem_rd_data),
      .common_set        (common_set),
      .block_set         (block_set),
      .side_i_set        (side_i_set),
      .side_j_set        (side_j_set),
      .common_edges      (common_edges),
      .bridge_edges      (bridge_edges),
      .block_edges       (block_edges),
      .max_bridge_degree (max_bridge_degree)
   );

   // An invalid result reports the block size and nothing else.
   assign result_ok = (|common_set) || ((|side_i_set) && (|side_j_set));

   always_comb begin
      result            = '0;
      result.block_size = SIZE_W'(popcount(MAX_NODES'(block_set)));
      if (result_ok) begin
         result.valid_res         = 1'b1;
         result.common_count      = SIZE_W'(popcount(MAX_NODES'(common_set)));
         result.common_edges      = common_edges;
         result.bridge_edges      = bridge_edges;
         result.max_bridge_degree = max_bridge_degree;
         result.block_edges       = block_edges;
         result.block_mask        = MASK_W'(block_set);
         result.side_i_mask       = MASK_W'(common_set | side_i_set);
         result.side_j_mask       = MASK_W'(common_set | side_j_set);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_data_ff;

   // The row memory port is never asked to write and read in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("row memory written and read in the same cycle");

   // An invalid result carries only the block size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.valid_res |->
         rsp_data_ff.common_count == '0 && rsp_data_ff.common_edges == '0 &&
         rsp_data_ff.bridge_edges == '0 && rsp_data_ff.max_bridge_degree == '0 &&
         rsp_data_ff.block_edges == '0 && rsp_data_ff.block_mask == '0 &&
         rsp_data_ff.side_i_mask == '0 && rsp_data_ff.side_j_mask == '0)
      else $error("invalid result has nonzero fields");

   // Both side masks lie inside the block mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.side_i_mask & ~rsp_data_ff.block_mask) == '0 &&
         (rsp_data_ff.side_j_mask & ~rsp_data_ff.block_mask) == '0)
      else $error("side mask outside block mask");

   // A query transfer takes the block out of idle in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_port.payload.func == FUNC_QUERY) |=> !ctrl_idle)
      else $error("query transfer did not start a query");

endmodule
